### src/sltc_pkg.sv
// Shared types and constants for the streaming local triangle counter.
// No dependencies; imported by every module of the block but sltc_ram.
package sltc_pkg;

    // Fixed field widths of the stream payload
    localparam int NODE_FW     = 6;
    localparam int SMALL_FW    = 6;
    localparam int TRI_FW      = 32;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;

    // Result field positions inside m_tdata
    localparam int OUT_NEW_LSB     = 0;
    localparam int OUT_DEG_LSB     = 6;
    localparam int OUT_TRI_LSB     = 12;
    localparam int OUT_PRESENT_BIT = 44;
    localparam int OUT_SELF_BIT    = 45;

    localparam logic [SMALL_FW-1:0] SMALL_MAX = '1;
    localparam logic [TRI_FW-1:0]   TRI_MAX   = '1;

    // Request kinds carried on s_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_LINK_A,
        ST_LINK_B,
        ST_SCAN,
        ST_DRAIN,
        ST_WR_A,
        ST_WR_B,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RSEL_A,
        RSEL_B,
        RSEL_SCAN
    } rd_sel_t;

    typedef struct packed {
        logic    latch_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    cap_a;
        logic    cap_b;
        logic    link_a;
        logic    link_b;
        logic    scan;
        logic    wr_a;
        logic    wr_b;
        logic    clr;
        logic    out_load;
    } sltc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic a_bad;
        logic b_bad;
        logic same;
        logic scan_last;
        logic out_free;
    } sltc_status_t;

endpackage

### src/streaming_local_triangle_counter.sv
// Top level of the streaming local triangle counter.
// Depends on sltc_pkg, sltc_ctrl, sltc_dp (which holds two sltc_ram instances).
//
// Usage:
//   Input stream (s_): one request per transfer. s_tuser = 1 reads the counters
//   of node_a; s_tuser = 0 inserts the undirected edge {node_a, node_b}.
//   Result stream (m_): exactly one result per request, in request order.
//   An insert bumps the triangle counter of both ends by the number of common
//   neighbors and each common neighbor by one; a repeated edge counts again.
//   A self-loop insert changes nothing and raises self_loop.
// Timing:
//   The block works on one request at a time. A read, a self-loop or a request
//   naming an out-of-range node skips the link, scan and write steps. An insert
//   reads both ends, links them, scans up to the highest common neighbor and
//   writes both counters; the scan walks the common-neighbor bitmap one node per
//   cycle, doing one read-modify-write of the counter memory for each common
//   neighbor. The result is registered and shows on m_ in the cycle after the
//   request's last state.
// Reset:
//   aresetn clears control state, then a clearing pass writes zero to every
//   row of both memories, with s_tready held low.
// Stall:
//   A result waiting on m_tready does not block the next request; only the
//   following result waits until the output register frees.
module streaming_local_triangle_counter #(
    parameter int NODES      = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, from bit 0: node_a[5:0], node_b[11:6], zero[15:12]
    input  logic [sltc_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd (0 = insert edge, 1 = read node_a)
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, from bit 0: new_triangles[5:0], node_degree[11:6],
    // node_triangles[43:12], node_present[44], self_loop[45], zero[47:46]
    output logic [sltc_pkg::M_TDATA_W-1:0] m_tdata
);
    import sltc_pkg::*;

    sltc_cmd_t    cmd;
    sltc_status_t status;

    // Sequencer: decides which step of the request runs in each cycle
    sltc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage, scan and result register
    sltc_dp #(
        .NODES      (NODES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_cmd    (s_tuser),
        .in_node_a (s_tdata[NODE_FW-1:0]),
        .in_node_b (s_tdata[2*NODE_FW-1:NODE_FW]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule

### src/sltc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sltc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### src/sltc_ctrl.sv
// Controller state machine of the triangle counter.
// Depends on sltc_pkg; drives the datapath through sltc_cmd_t.
module sltc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sltc_pkg::sltc_status_t status,
    output sltc_pkg::sltc_cmd_t    cmd
);
    import sltc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_RD_A;
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B: begin
                if (status.is_read || status.a_bad || status.same || status.b_bad) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_LINK_A;
                end
            end
            ST_LINK_A: state_next = ST_LINK_B;
            ST_LINK_B: state_next = ST_SCAN;
            ST_SCAN:   if (status.scan_last) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_WR_A;
            ST_WR_A:   state_next = ST_WR_B;
            ST_WR_B:   state_next = ST_FINISH;
            ST_FINISH: if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr = 1'b1;
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            ST_RD_A: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RSEL_A;
            end
            ST_RD_B: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RSEL_B;
                cmd.cap_a  = 1'b1;
            end
            ST_LINK_A: begin
                cmd.cap_b  = 1'b1;
                cmd.link_a = 1'b1;
            end
            ST_LINK_B: cmd.link_b = 1'b1;
            ST_SCAN: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RSEL_SCAN;
                cmd.scan   = 1'b1;
            end
            ST_DRAIN:  cmd = '0;
            ST_WR_A:   cmd.wr_a = 1'b1;
            ST_WR_B:   cmd.wr_b = 1'b1;
            ST_FINISH: cmd.out_load = status.out_free;
            default:   cmd = '0;
        endcase
    end
endmodule

### src/sltc_dp.sv
// Datapath of the triangle counter: request registers, adjacency and
// counter memories, neighbor scan and result register. Depends on sltc_pkg, sltc_ram.
module sltc_dp #(
    parameter int NODES      = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sltc_pkg::sltc_cmd_t               cmd,
    output sltc_pkg::sltc_status_t            status,
    input  logic                              in_cmd,
    input  logic [sltc_pkg::NODE_FW-1:0]      in_node_a,
    input  logic [sltc_pkg::NODE_FW-1:0]      in_node_b,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sltc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import sltc_pkg::*;

    localparam int NODE_W = $clog2(NODES);
    localparam int DEG_W  = $clog2(NODES);
    localparam int CNT_W  = COUNT_BITS + DEG_W;
    localparam int SUM_W  = COUNT_BITS + DEG_W;
    localparam int TEXT_W = (COUNT_BITS > TRI_FW) ? COUNT_BITS : TRI_FW;

    logic                  cmd_reg;
    logic [NODE_FW-1:0]    a_reg;
    logic [NODE_FW-1:0]    b_reg;
    logic [NODES-1:0]      row_a_reg;
    logic [NODES-1:0]      row_b_reg;
    logic [DEG_W-1:0]      deg_a_reg;
    logic [DEG_W-1:0]      deg_b_reg;
    logic [COUNT_BITS-1:0] tri_a_reg;
    logic [COUNT_BITS-1:0] tri_b_reg;
    logic [DEG_W-1:0]      found_reg;
    logic [NODES-1:0]      common_reg;
    logic [NODE_W-1:0]     scan_idx_reg;
    logic [NODE_W-1:0]     wr_idx_reg;
    logic                  hit_reg;
    logic [NODE_W-1:0]     clr_idx_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [NODE_W-1:0]     a_addr;
    logic [NODE_W-1:0]     b_addr;
    logic [NODES-1:0]      bit_a;
    logic [NODES-1:0]      bit_b;

    logic                  adj_we;
    logic [NODE_W-1:0]     adj_waddr;
    logic [NODES-1:0]      adj_wdata;
    logic [NODE_W-1:0]     adj_raddr;
    logic [NODES-1:0]      adj_rdata;

    logic                  cnt_we;
    logic [NODE_W-1:0]     cnt_waddr;
    logic [CNT_W-1:0]      cnt_wdata;
    logic [NODE_W-1:0]     cnt_raddr;
    logic [CNT_W-1:0]      cnt_rdata;
    logic [DEG_W-1:0]      cnt_rd_deg;
    logic [COUNT_BITS-1:0] cnt_rd_tri;

    logic                  ok_a;
    logic [SMALL_FW-1:0]   out_new;
    logic [SMALL_FW-1:0]   out_deg;
    logic [TRI_FW-1:0]     out_tri;
    logic                  out_present;
    logic                  out_self;
    logic [TEXT_W-1:0]     tri_ext;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] base,
        input logic [DEG_W-1:0]      amount
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(amount);
        if (sum[SUM_W-1:COUNT_BITS] != '0) begin
            return '1;
        end
        return sum[COUNT_BITS-1:0];
    endfunction

    assign a_addr = NODE_W'(a_reg);
    assign b_addr = NODE_W'(b_reg);
    assign bit_a  = {{(NODES-1){1'b0}}, 1'b1} << a_addr;
    assign bit_b  = {{(NODES-1){1'b0}}, 1'b1} << b_addr;

    // Status toward the controller
    assign status.clr_last  = (clr_idx_reg == NODE_W'(NODES - 1));
    assign status.is_read   = (cmd_reg == CMD_READ);
    assign status.a_bad     = (32'(a_reg) >= NODES);
    assign status.b_bad     = (32'(b_reg) >= NODES);
    assign status.same      = (a_reg == b_reg);
    assign status.scan_last = (common_reg[NODES-1:1] == '0);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // Adjacency memory ports
    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = a_addr;
        adj_wdata = row_a_reg | bit_b;
        if (cmd.clr) begin
            adj_we    = 1'b1;
            adj_waddr = clr_idx_reg;
            adj_wdata = '0;
        end else if (cmd.link_a) begin
            adj_we    = 1'b1;
        end else if (cmd.link_b) begin
            adj_we    = 1'b1;
            adj_waddr = b_addr;
            adj_wdata = row_b_reg | bit_a;
        end
    end

    assign adj_raddr = (cmd.rd_sel == RSEL_B) ? b_addr : a_addr;

    // Counter memory ports: word is {triangles, degree}
    assign cnt_rd_deg = cnt_rdata[DEG_W-1:0];
    assign cnt_rd_tri = cnt_rdata[CNT_W-1:DEG_W];

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = wr_idx_reg;
        cnt_wdata = {sat_add(cnt_rd_tri, DEG_W'(1)), cnt_rd_deg};
        if (cmd.clr) begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_idx_reg;
            cnt_wdata = '0;
        end else if (hit_reg) begin
            cnt_we    = 1'b1;
        end else if (cmd.wr_a) begin
            cnt_we    = 1'b1;
            cnt_waddr = a_addr;
            cnt_wdata = {sat_add(tri_a_reg, found_reg), deg_a_reg};
        end else if (cmd.wr_b) begin
            cnt_we    = 1'b1;
            cnt_waddr = b_addr;
            cnt_wdata = {sat_add(tri_b_reg, found_reg), deg_b_reg};
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            RSEL_A:    cnt_raddr = a_addr;
            RSEL_B:    cnt_raddr = b_addr;
            RSEL_SCAN: cnt_raddr = scan_idx_reg;
            default:   cnt_raddr = a_addr;
        endcase
    end

    sltc_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_adj_ram (
        .aclk    (aclk),
        .wr_en   (adj_we),
        .wr_addr (adj_waddr),
        .wr_data (adj_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (adj_raddr),
        .rd_data (adj_rdata)
    );

    sltc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NODES)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_idx_reg <= clr_idx_reg + NODE_W'(1);
            end
            hit_reg <= cmd.scan && common_reg[0];
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            cmd_reg   <= in_cmd;
            a_reg     <= in_node_a;
            b_reg     <= in_node_b;
            found_reg <= '0;
        end
        if (cmd.cap_a) begin
            row_a_reg <= adj_rdata;
            deg_a_reg <= cnt_rd_deg;
            tri_a_reg <= cnt_rd_tri;
        end
        if (cmd.cap_b) begin
            row_b_reg <= adj_rdata;
            deg_b_reg <= cnt_rd_deg;
            tri_b_reg <= cnt_rd_tri;
        end
        if (cmd.link_a) begin
            row_a_reg <= row_a_reg | bit_b;
            deg_a_reg <= deg_a_reg + DEG_W'(!row_a_reg[b_addr]);
        end
        if (cmd.link_b) begin
            row_b_reg    <= row_b_reg | bit_a;
            deg_b_reg    <= deg_b_reg + DEG_W'(!row_b_reg[a_addr]);
            common_reg   <= row_a_reg & row_b_reg;
            scan_idx_reg <= '0;
        end
        if (cmd.scan) begin
            common_reg   <= common_reg >> 1;
            scan_idx_reg <= scan_idx_reg + NODE_W'(1);
            wr_idx_reg   <= scan_idx_reg;
            if (common_reg[0]) begin
                found_reg <= found_reg + DEG_W'(1);
            end
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {2'b00, out_self, out_present, out_tri, out_deg, out_new};
        end
    end

    // Result fields; an out-of-range node_a reports all zero.
    // node_a's count includes the triangles this request just closed.
    assign ok_a    = !status.a_bad;
    assign tri_ext = TEXT_W'(sat_add(tri_a_reg, found_reg));

    always_comb begin
        out_new     = (32'(found_reg) > 32'(SMALL_MAX)) ? SMALL_MAX : SMALL_FW'(found_reg);
        out_deg     = (32'(deg_a_reg) > 32'(SMALL_MAX)) ? SMALL_MAX : SMALL_FW'(deg_a_reg);
        out_tri     = (tri_ext > TEXT_W'(TRI_MAX)) ? TRI_MAX : TRI_FW'(tri_ext);
        out_present = (deg_a_reg != '0);
        out_self    = !status.is_read && status.same;
        if (!ok_a) begin
            out_new     = '0;
            out_deg     = '0;
            out_tri     = '0;
            out_present = 1'b0;
            out_self    = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

### src/sltc_checker.sv
// Port-level checks for the streaming local triangle counter.
// Depends on sltc_pkg; bound to streaming_local_triangle_counter below.
module sltc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sltc_pkg::M_TDATA_W-1:0] m_tdata
);
    import sltc_pkg::*;

    // Reset drops any pending result
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The clearing pass keeps the input closed right after reset
    a_reset_in: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // One request at a time: ready drops after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted on consecutive cycles");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Presence agrees with degree, and a self-loop closes no triangle
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_PRESENT_BIT] == (m_tdata[OUT_DEG_LSB +: SMALL_FW] != '0))
                  && (!m_tdata[OUT_SELF_BIT] || (m_tdata[OUT_NEW_LSB +: SMALL_FW] == '0)))
        else $error("inconsistent result fields");
endmodule

bind streaming_local_triangle_counter sltc_checker u_sltc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/streaming_local_triangle_counter_tb.sv
// Self-checking testbench for streaming_local_triangle_counter: edge inserts and
// node reads are checked against a bit-exact graph predictor held in a scoreboard.
// Depends on sltc_pkg and the streaming_local_triangle_counter RTL only.
module streaming_local_triangle_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sltc_pkg::*;

    localparam int NODE_COUNT       = 64;
    localparam int CYCLE_LIMIT      = 1_000_000;
    // Covers the slowest insert, with a little more for the tail.
    localparam int DRAIN_CYCLES     = 100;
    localparam int RANDOM_PER_PHASE = 505;
    localparam int HUB_NODE         = 7;
    localparam int CLUSTER_SPAN     = 12;
    localparam int HOLD_OFF_CYCLES  = 300;

    // Fields of one result, in the order they sit in m_tdata.
    typedef struct {
        logic [SMALL_FW-1:0] new_triangles;
        logic [SMALL_FW-1:0] node_degree;
        logic [TRI_FW-1:0]   node_triangles;
        logic                node_present;
        logic                self_loop;
    } node_report_t;

    // Graph predictor plus the queue of reports still owed by the block.
    class triangle_scoreboard;
        logic [NODE_COUNT-1:0] adjacency[NODE_COUNT];
        logic [6:0]            degree_of[NODE_COUNT];
        logic [TRI_FW-1:0]     triangles_of[NODE_COUNT];
        node_report_t          pending_reports[$];
        int                    mismatches;

        function new();
            foreach (adjacency[i]) begin
                adjacency[i]    = '0;
                degree_of[i]    = '0;
                triangles_of[i] = '0;
            end
            mismatches = 0;
        endfunction

        function logic [TRI_FW-1:0] add_saturated(logic [TRI_FW-1:0] cur, int unsigned amount);
            longint unsigned sum;
            sum = longint'(cur) + longint'(amount);
            return (sum > longint'(TRI_MAX)) ? TRI_MAX : sum[TRI_FW-1:0];
        endfunction

        // Apply one accepted request to the graph and queue the report it owes.
        function void note_request(logic cmd, logic [NODE_FW-1:0] a, logic [NODE_FW-1:0] b);
            node_report_t          rep;
            logic [NODE_COUNT-1:0] common;
            int unsigned           found;
            rep = '{default: '0};
            found = 0;
            if (cmd == CMD_INSERT) begin
                if (a == b) begin
                    rep.self_loop = 1'b1;
                end else begin
                    if (!adjacency[a][b]) begin
                        adjacency[a][b] = 1'b1;
                        degree_of[a]++;
                    end
                    if (!adjacency[b][a]) begin
                        adjacency[b][a] = 1'b1;
                        degree_of[b]++;
                    end
                    // Every common neighbor closes one triangle, repeated edge or not.
                    common = adjacency[a] & adjacency[b];
                    for (int w = 0; w < NODE_COUNT; w++) begin
                        if (common[w]) begin
                            found++;
                            triangles_of[w] = add_saturated(triangles_of[w], 1);
                        end
                    end
                    triangles_of[a] = add_saturated(triangles_of[a], found);
                    triangles_of[b] = add_saturated(triangles_of[b], found);
                    rep.new_triangles = (found > 63) ? SMALL_MAX : found[SMALL_FW-1:0];
                end
            end
            rep.node_degree    = (degree_of[a] > 63) ? SMALL_MAX : degree_of[a][SMALL_FW-1:0];
            rep.node_triangles = triangles_of[a];
            rep.node_present   = (degree_of[a] != 0);
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            node_report_t want;
            if (pending_reports.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual 0x%h",
                         $time, data);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("new_triangles", 64'(want.new_triangles),
                          64'(data[OUT_NEW_LSB +: SMALL_FW]));
            compare_field("node_degree", 64'(want.node_degree),
                          64'(data[OUT_DEG_LSB +: SMALL_FW]));
            compare_field("node_triangles", 64'(want.node_triangles),
                          64'(data[OUT_TRI_LSB +: TRI_FW]));
            compare_field("node_present", 64'(want.node_present),
                          64'(data[OUT_PRESENT_BIT]));
            compare_field("self_loop", 64'(want.self_loop), 64'(data[OUT_SELF_BIT]));
        endfunction

        function int outstanding();
            return pending_reports.size();
        endfunction
    endclass

    // Every input holds a known value from time zero.
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = CMD_INSERT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    triangle_scoreboard sb = new();

    // Stall knobs, set per phase by the stimulus process.
    int                send_gap_pct  = 0;
    int                recv_gap_pct  = 0;
    int                hold_request  = 0;
    int                cycle_count   = 0;
    int                cluster_base  = 0;
    logic [NODE_FW-1:0] hub_next     = '0;

    streaming_local_triangle_counter #(
        .NODES      (NODE_COUNT),
        .COUNT_BITS (32)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // from bit 0: node_a, node_b, zero padding
        .s_tdata  (s_tdata),
        // cmd: insert edge or read node_a
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // from bit 0: new_triangles, node_degree, node_triangles, node_present,
        // self_loop, zero padding
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop; far above the slowest legal run including the clearing pass.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("streaming_local_triangle_counter_tb NOT OK");
        $finish;
    end

    // Result side backpressure. A hold-off request from the stimulus turns into a
    // countdown here, during which m_tready stays low whatever the idle rate is.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // Sample both handshakes with the values that held up to the edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[0 +: NODE_FW], s_tdata[NODE_FW +: NODE_FW]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Offer one request, with random idle cycles ahead of it, and hold it until
    // accepted. Returns at the accepting edge, so the caller drives the next step.
    task automatic send_request(logic cmd, logic [NODE_FW-1:0] a, logic [NODE_FW-1:0] b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - 2 * NODE_FW){1'b0}}, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Many are inserts that build structure: a hub that walks every node, so its
    // degree tops out, and a dense cluster that closes many triangles. The rest
    // are reads, self-loops and scattered edges over the whole node range.
    task automatic send_random_request();
        int                 pick;
        logic               cmd;
        logic [NODE_FW-1:0] a;
        logic [NODE_FW-1:0] b;
        pick = $urandom_range(0, 99);
        cmd  = CMD_INSERT;
        a    = NODE_FW'($urandom_range(0, NODE_COUNT - 1));
        b    = NODE_FW'($urandom_range(0, NODE_COUNT - 1));
        if (pick < 20) begin
            cmd = CMD_READ;
        end else if (pick < 24) begin
            b = a;
        end else if (pick < 34) begin
            a = NODE_FW'(HUB_NODE);
            b = hub_next;
            hub_next++;
        end else if (pick < 72) begin
            a = NODE_FW'(cluster_base + int'($urandom_range(0, CLUSTER_SPAN - 1)));
            b = NODE_FW'(cluster_base + int'($urandom_range(0, CLUSTER_SPAN - 1)));
        end
        send_request(cmd, a, b);
    endtask

    // Drop valid, then hold the sender back until every report has arrived.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        cluster_base = $urandom_range(0, NODE_COUNT - CLUSTER_SPAN);
        repeat (RANDOM_PER_PHASE) send_random_request();
        wait_idle();
    endtask

    initial begin
        // Hold reset, then release it; the clearing pass that follows keeps s_tready low.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reads of empty nodes, node_b ignored with all its bits set or clear.
        send_request(CMD_READ, 6'd0, 6'd63);
        send_request(CMD_READ, 6'd63, 6'd0);
        // Self-loops on empty nodes change nothing.
        send_request(CMD_INSERT, 6'd0, 6'd0);
        send_request(CMD_INSERT, 6'd63, 6'd63);
        // Build the triangle {0, 63, 1} from the extremes.
        send_request(CMD_INSERT, 6'd0, 6'd63);
        send_request(CMD_INSERT, 6'd63, 6'd1);
        send_request(CMD_INSERT, 6'd0, 6'd1);
        // Repeated edge, reversed: the same triangle counts again.
        send_request(CMD_INSERT, 6'd1, 6'd0);
        // Node 2 joins: no triangle, then one, then two closed by a single edge.
        send_request(CMD_INSERT, 6'd2, 6'd0);
        send_request(CMD_INSERT, 6'd2, 6'd1);
        send_request(CMD_INSERT, 6'd2, 6'd63);
        // Self-loop on a node that has edges reports its counters.
        send_request(CMD_INSERT, 6'd1, 6'd1);
        send_request(CMD_READ, 6'd0, 6'd42);
        send_request(CMD_READ, 6'd1, 6'd21);
        send_request(CMD_READ, 6'd2, 6'd63);
        send_request(CMD_READ, 6'd63, 6'd63);
        // Alternating bit patterns, an isolated edge and its repeat.
        send_request(CMD_INSERT, 6'd42, 6'd21);
        send_request(CMD_INSERT, 6'd21, 6'd42);
        send_request(CMD_READ, 6'd42, 6'd21);
        // Repeat of an edge that closes two triangles.
        send_request(CMD_INSERT, 6'd63, 6'd0);
        send_request(CMD_READ, 6'd63, 6'd0);
        wait_idle();

        run_phase(34, 80);
        run_phase(80, 34);

        // Block the result side for a long stretch while the sender keeps offering,
        // so the output register fills and the block stalls its input.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (12) send_random_request();
        wait_idle();

        run_phase(0, 0);

        // Let any stray result surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("streaming_local_triangle_counter_tb OK");
        else
            $display("streaming_local_triangle_counter_tb NOT OK");
        $finish;
    end

endmodule
